/* rtl/p15iq_pkg.sv */
package p15iq_pkg;

  localparam int unsigned WORD_W    = 16;
  localparam int unsigned SHIFT_W   = 4;
  localparam int unsigned STATE_W   = 32;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned EBITS_W   = 5;
  localparam int unsigned IDX_W     = 2;
  localparam int unsigned IN_DATA_W = 32;
  localparam int unsigned OUT_DATA_W = 112;

  localparam logic [CNT_W-1:0]   SYNC_WORDS = 5'd20;
  localparam logic [EBITS_W-1:0] LOSS_BITS  = 5'd6;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd4;
  localparam logic [WORD_W-1:0]  MASK_RESET  = 16'h0ffe;

  localparam logic [IDX_W-1:0] REG_DATA_SHIFT = 2'd0;
  localparam logic [IDX_W-1:0] REG_CHECK_MASK = 2'd1;
  localparam logic [IDX_W-1:0] REG_INVERT_I   = 2'd2;
  localparam logic [IDX_W-1:0] REG_INVERT_Q   = 2'd3;

  typedef struct packed {
    logic [SHIFT_W-1:0] shift;
    logic [WORD_W-1:0]  mask;
    logic               inv;
  } lane_cfg_t;

  typedef struct packed {
    logic               match;
    logic [EBITS_W-1:0] err_bits;
    logic [WORD_W-1:0]  err_mask;
    logic               lost;
    logic [STATE_W-1:0] resyncs;
  } lane_res_t;

endpackage

/* rtl/p15iq_lane.sv */
module p15iq_lane (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      fire,
  input  logic [15:0]               word,
  input  p15iq_pkg::lane_cfg_t      cfg,
  output p15iq_pkg::lane_res_t      res
);
  import p15iq_pkg::*;

  logic               seeded;
  logic               seeded_next;
  logic [CNT_W-1:0]   sync_count;
  logic [CNT_W-1:0]   sync_count_next;
  logic [STATE_W-1:0] lfsr_track;
  logic [STATE_W-1:0] lfsr_track_next;
  logic [STATE_W-1:0] predicted;
  logic [STATE_W-1:0] predicted_next;
  logic [STATE_W-1:0] resync_total;
  logic [STATE_W-1:0] resync_total_next;

  logic [WORD_W-1:0]  a;
  logic [WORD_W-1:0]  mweigh;
  logic [STATE_W-1:0] st_sh;
  logic [WORD_W-1:0]  diff;
  logic [2:0]         nib_cnt [4];
  logic [EBITS_W-1:0] ones;
  logic               in_sync;
  logic               fb;

  assign a       = word >> cfg.shift;
  assign mweigh  = cfg.mask | 16'h0001;
  assign st_sh   = {lfsr_track[STATE_W-2:0], 1'b0};
  assign diff    = (a ^ st_sh[WORD_W-1:0]) & mweigh;
  assign in_sync = (sync_count >= SYNC_WORDS);
  assign fb      = lfsr_track[14] ^ lfsr_track[13];

  // nibble counts, then a small adder tree
  always_comb begin
    for (int g = 0; g < 4; g++) begin
      nib_cnt[g] = {2'b00, diff[4*g]} + {2'b00, diff[4*g+1]}
                 + {2'b00, diff[4*g+2]} + {2'b00, diff[4*g+3]};
    end
    ones = ({2'b00, nib_cnt[0]} + {2'b00, nib_cnt[1]})
         + ({2'b00, nib_cnt[2]} + {2'b00, nib_cnt[3]});
  end

  always_comb begin
    seeded_next       = seeded;
    sync_count_next   = sync_count;
    lfsr_track_next   = lfsr_track;
    resync_total_next = resync_total;
    res.err_bits      = '0;
    res.err_mask      = '0;
    res.lost          = 1'b0;
    if (!seeded) begin
      lfsr_track_next = {{(STATE_W-WORD_W){1'b0}}, a};
      seeded_next     = 1'b1;
    end else if ((st_sh[WORD_W-1:0] & cfg.mask) == (a & cfg.mask)) begin
      lfsr_track_next = st_sh | {{(STATE_W-WORD_W){1'b0}}, a};
      if (!in_sync) begin
        sync_count_next = sync_count + 5'd1;
      end
    end else if (!in_sync) begin
      lfsr_track_next = st_sh | {{(STATE_W-1){1'b0}}, a[0]};
      sync_count_next = sync_count + 5'd1;
    end else begin
      res.err_bits = ones;
      res.err_mask = diff;
      if (ones >= LOSS_BITS) begin
        lfsr_track_next   = '0;
        resync_total_next = resync_total + 32'd1;
        seeded_next       = 1'b0;
        sync_count_next   = '0;
        res.lost          = 1'b1;
      end else begin
        // repair from the LFSR prediction
        lfsr_track_next = {st_sh[STATE_W-1:1], fb ^ cfg.inv};
      end
    end
    predicted_next = {lfsr_track_next[STATE_W-2:0],
                      lfsr_track_next[14] ^ lfsr_track_next[13] ^ cfg.inv};
    res.match      = (predicted == lfsr_track_next);
    res.resyncs    = resync_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seeded       <= 1'b0;
      sync_count   <= '0;
      lfsr_track   <= '0;
      predicted    <= '0;
      resync_total <= '0;
    end else if (fire) begin
      seeded       <= seeded_next;
      sync_count   <= sync_count_next;
      lfsr_track   <= lfsr_track_next;
      predicted    <= predicted_next;
      resync_total <= resync_total_next;
    end
  end

endmodule

/* rtl/p15iq_merge.sv */
module p15iq_merge (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  p15iq_pkg::lane_res_t   res_i,
  input  p15iq_pkg::lane_res_t   res_q,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [111:0]           m_tdata
);
  import p15iq_pkg::*;

  logic                  fire;
  logic [OUT_DATA_W-1:0] packed_res;

  assign in_ready = !m_tvalid || m_tready;
  assign fire     = in_valid && in_ready;

  assign packed_res = {2'b00,
                       res_q.resyncs, res_i.resyncs,
                       res_q.lost, res_i.lost,
                       res_q.err_mask, res_i.err_mask,
                       res_q.err_bits, res_i.err_bits,
                       res_q.match, res_i.match};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= packed_res;
    end
  end

endmodule

/* rtl/prbs15_iq_lane_checker_core.sv */
// PRBS15 checker for one I and one Q interface lane.
// Input stream s_*: one transfer carries a raw I word and a raw Q word.
// Output stream m_*: one transfer per input transfer, in order, with the
// per-lane match flag, error weight and mask, sync-loss flag and the
// running resync count.
// Both lanes run side by side in their own checker; a merge stage packs
// the two lane results into a single output register.
// Output: m_tvalid is registered and rises in the cycle after an input transfer.
// Throughput: one item per clock while m_tready is high; lane state is registered on each transfer.
// s_tready is high while the output register is empty or being taken,
// so a stalled receiver holds its result and stalls the input after one
// item; nothing is dropped.
// Configuration (cfg_wr_en, cfg_index, cfg_data) is to be written by the user
// only while idle, which the block does not enforce: 0 data_shift, 1 check_mask, 2 invert_i, 3 invert_q.
// Synchronous reset clears lane state, resync counts and output valid,
// and restores the register defaults.
module prbs15_iq_lane_checker_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [15:0] word_i, [31:16] word_q
  input  logic [p15iq_pkg::IN_DATA_W-1:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [0] match_i, [1] match_q, [6:2] err_bits_i, [11:7] err_bits_q,
  // [27:12] err_mask_i, [43:28] err_mask_q, [44] lost_i, [45] lost_q,
  // [77:46] resyncs_i, [109:78] resyncs_q, [111:110] zero
  output logic [111:0] m_tdata,
  input  logic         cfg_wr_en,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);
  import p15iq_pkg::*;

  logic [SHIFT_W-1:0] data_shift;
  logic [WORD_W-1:0]  check_mask;
  logic               invert_i;
  logic               invert_q;
  logic               fire;
  lane_cfg_t          cfg_i;
  lane_cfg_t          cfg_q;
  lane_res_t          res_i;
  lane_res_t          res_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      data_shift <= SHIFT_RESET;
      check_mask <= MASK_RESET;
      invert_i   <= 1'b0;
      invert_q   <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_DATA_SHIFT: data_shift <= cfg_data[SHIFT_W-1:0];
        REG_CHECK_MASK: check_mask <= cfg_data;
        REG_INVERT_I:   invert_i   <= cfg_data[0];
        REG_INVERT_Q:   invert_q   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign fire  = s_tvalid && s_tready;
  assign cfg_i = '{shift: data_shift, mask: check_mask, inv: invert_i};
  assign cfg_q = '{shift: data_shift, mask: check_mask, inv: invert_q};

  p15iq_lane u_lane_i (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .word (s_tdata[15:0]),
    .cfg  (cfg_i),
    .res  (res_i)
  );

  p15iq_lane u_lane_q (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .word (s_tdata[31:16]),
    .cfg  (cfg_q),
    .res  (res_q)
  );

  p15iq_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .res_i    (res_i),
    .res_q    (res_q),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
